[design/assert_macros.svh]
// Assertion macros for the heap RTL.
// Depends on a clock named clk and a reset named rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define MHIRQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define MHIRQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/mhirq_pkg.sv]
// Package for the min-heap insert and relation query block.
// Holds item kind codes and the control state type; no dependencies.
`default_nettype none

package mhirq_pkg;

  // Item kind codes
  localparam logic [2:0] KIND_INSERT  = 3'd0;
  localparam logic [2:0] KIND_ROOT    = 3'd1;
  localparam logic [2:0] KIND_PARENT  = 3'd2;
  localparam logic [2:0] KIND_CHILD   = 3'd3;
  localparam logic [2:0] KIND_SIBLING = 3'd4;

  // Control states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIFT,
    ST_PLACE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

[design/mhirq_relate.sv]
// Relation check between two 1-based heap positions.
// Depends on mhirq_pkg for the kind codes; a position of zero means not found.
`default_nettype none

module mhirq_relate
  import mhirq_pkg::*;
#(
  parameter int PW = 11
) (
  input  wire logic [2:0]    kind,
  input  wire logic [PW-1:0] pa,
  input  wire logic [PW-1:0] pb,
  output logic               answer
);

  logic [PW-1:0] lo;
  logic [PW-1:0] hi;
  logic          both_found;

  // order the pair for the sibling test
  assign lo         = (pa < pb) ? pa : pb;
  assign hi         = (pa < pb) ? pb : pa;
  assign both_found = (pa != '0) && (pb != '0);

  always_comb begin
    case (kind)
      KIND_ROOT:    answer = (pa == PW'(1));
      KIND_PARENT:  answer = both_found && (pa == (pb >> 1));
      KIND_CHILD:   answer = both_found && ((pa >> 1) == pb);
      // positions 2k and 2k+1
      KIND_SIBLING: answer = (lo != '0) && hi[0] &&
                             (({1'b0, lo} + 1'b1) == {1'b0, hi});
      default:      answer = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

[design/min_heap_insert_relation_query.sv]
// Min-heap of signed 16-bit keys with sift-up insert and relation queries.
// Insert: moves up one parent level per step (at most log2(HEAP_DEPTH) levels),
//   a read-compare-write walk on the single heap memory; no walk when empty or full.
// Query: one stored key read per cycle in a linear scan over the stored entries.
// One item at a time; the next item is taken while a result waits in the output register.
// Reset (synchronous) clears the entry count and handshakes; memory is not cleared.
`default_nettype none

module min_heap_insert_relation_query
  import mhirq_pkg::*;
#(
  parameter int HEAP_DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input items
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [15:0] key_a, [31:16] key_b
  input  wire logic [2:0]  s_tuser,   // [2:0] kind
  // result items
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata    // [0] answer, [1] status, [7:2] zero
);

  localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW = $clog2(HEAP_DEPTH + 1);

  state_t state, state_next;

  // item registers
  logic [2:0]         kind;
  logic signed [15:0] key_a;
  logic signed [15:0] key_b;

  // heap control
  logic [CW-1:0] count;
  logic [AW-1:0] pos;
  logic [AW-1:0] par;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] cmp_pos;
  logic          cmp_valid;
  logic [CW-1:0] pa;
  logic [CW-1:0] pb;
  logic          res_answer;
  logic          res_status;
  logic          rel_answer;

  // memory port
  logic signed [15:0] mem [HEAP_DEPTH];
  logic signed [15:0] rdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic signed [15:0] mem_wdata;

  logic          accept;
  logic          out_free;
  logic          scan_rd;
  logic          keep_sifting;
  logic [CW-1:0] cnt_par;
  logic [AW-1:0] par_par;
  logic signed [15:0] in_key_a;

  assign s_tready     = (state == ST_IDLE);
  assign accept       = s_tvalid && s_tready;
  assign out_free     = !m_tvalid || m_tready;
  assign in_key_a     = $signed(s_tdata[15:0]);
  assign cnt_par      = (count - 1'b1) >> 1;
  assign par_par      = (par - 1'b1) >> 1;
  assign scan_rd      = (rd_idx < count);
  assign keep_sifting = (rdata > key_a);

  // single memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  mhirq_relate #(
    .PW(CW)
  ) u_relate (
    .kind  (kind),
    .pa    (pa),
    .pb    (pb),
    .answer(rel_answer)
  );

  // next state and memory controls
  always_comb begin
    state_next = state;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = key_a;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_tuser == KIND_INSERT) begin
            if (count == CW'(HEAP_DEPTH)) begin
              state_next = ST_DONE;
            end else if (count == '0) begin
              mem_we     = 1'b1;
              mem_waddr  = '0;
              mem_wdata  = in_key_a;
              state_next = ST_DONE;
            end else begin
              mem_re     = 1'b1;
              mem_raddr  = cnt_par[AW-1:0];
              state_next = ST_SIFT;
            end
          end else if (s_tuser == KIND_ROOT || s_tuser == KIND_PARENT ||
                       s_tuser == KIND_CHILD || s_tuser == KIND_SIBLING) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SIFT: begin
        mem_we    = 1'b1;
        mem_waddr = pos;
        if (!keep_sifting) begin
          mem_wdata  = key_a;
          state_next = ST_DONE;
        end else begin
          // move the larger parent down one level
          mem_wdata = rdata;
          if (par == '0) begin
            state_next = ST_PLACE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = par_par;
          end
        end
      end
      ST_PLACE: begin
        mem_we     = 1'b1;
        mem_waddr  = pos;
        mem_wdata  = key_a;
        state_next = ST_DONE;
      end
      ST_SCAN: begin
        mem_re    = scan_rd;
        mem_raddr = rd_idx[AW-1:0];
        if (!scan_rd && !cmp_valid) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // entry count and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if ((state == ST_IDLE && accept && s_tuser == KIND_INSERT && count == '0) ||
          (state == ST_SIFT && !keep_sifting) || (state == ST_PLACE)) begin
        count <= count + 1'b1;
      end
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // item, walk and scan registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          kind       <= s_tuser;
          key_a      <= in_key_a;
          key_b      <= $signed(s_tdata[31:16]);
          pos        <= count[AW-1:0];
          par        <= cnt_par[AW-1:0];
          rd_idx     <= '0;
          cmp_valid  <= 1'b0;
          pa         <= '0;
          pb         <= '0;
          res_answer <= 1'b0;
          res_status <= (s_tuser == KIND_INSERT) && (count == CW'(HEAP_DEPTH));
        end
      end
      ST_SIFT: begin
        if (keep_sifting) begin
          pos <= par;
          par <= par_par;
        end
      end
      ST_SCAN: begin
        cmp_valid <= scan_rd;
        cmp_pos   <= rd_idx + 1'b1;
        if (scan_rd) begin
          rd_idx <= rd_idx + 1'b1;
        end
        // keep the first match of each key
        if (cmp_valid && rdata == key_a && pa == '0) begin
          pa <= cmp_pos;
        end
        if (cmp_valid && rdata == key_b && pb == '0) begin
          pb <= cmp_pos;
        end
        if (!scan_rd && !cmp_valid) begin
          res_answer <= rel_answer;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          m_tdata <= {6'b0, res_status, res_answer};
        end
      end
      default: begin
      end
    endcase
  end

  // checks
`include "assert_macros.svh"

  `MHIRQ_ASSERT_ALWAYS(a_count_bound, (rst || (count <= CW'(HEAP_DEPTH))), "entry count above depth")
  `MHIRQ_ASSERT(a_count_step, (!$past(rst) && count != $past(count)) |-> (count == $past(count) + 1'b1), "entry count moved by other than one")
  `MHIRQ_ASSERT(a_pos_in_range, (state == ST_SCAN) |-> (pa <= count && pb <= count), "found position beyond stored keys")
  `MHIRQ_ASSERT(a_first_match, (state == ST_SCAN && pa != '0) |=> (pa == $past(pa)), "first match position overwritten")

endmodule

`default_nettype wire

[test/min_heap_insert_relation_query_tb.sv]
// Testbench for min_heap_insert_relation_query: inserts and relation queries on a binary min-heap.
// Results are predicted by a heap kept in the testbench and checked field by field, in order.
// Depends on mhirq_pkg and the min_heap_insert_relation_query RTL.
`timescale 1ns / 1ps

module min_heap_insert_relation_query_tb;
  import mhirq_pkg::*;

  localparam int HEAP_DEPTH = 1024;
  localparam int GAP_PCT    = 13;

  typedef struct packed {
    logic answer;
    logic status;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [15:0] key_a, [31:16] key_b
  logic [2:0]  s_tuser = '0;   // [2:0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [0] answer, [1] status, [7:2] zero

  // Heap as the block should hold it, plus results still owed
  logic signed [15:0] heap_keys [HEAP_DEPTH];
  int                 heap_len = 0;
  result_t            due_results [$];
  int                 errors = 0;
  bit                 no_gaps = 1'b0;
  bit                 hold_pending = 1'b0;

  min_heap_insert_relation_query #(
    .HEAP_DEPTH(HEAP_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #4 clk = ~clk;

  // 1-based position of the first slot holding key, 0 when absent
  function automatic int heap_pos(logic signed [15:0] key);
    for (int i = 0; i < heap_len; i++)
      if (heap_keys[i] == key) return i + 1;
    return 0;
  endfunction

  // Apply one item to the heap and return the result it owes
  function automatic result_t heap_apply(logic [2:0] kind, logic signed [15:0] ka,
                                         logic signed [15:0] kb);
    result_t r;
    int slot, pa, pb, lo, hi;
    r = '0;
    case (kind)
      KIND_INSERT: begin
        if (heap_len >= HEAP_DEPTH) begin
          r.status = 1'b1;
        end else begin
          // sift up: larger parents move down one level
          slot = heap_len;
          while (slot > 0 && heap_keys[(slot - 1) / 2] > ka) begin
            heap_keys[slot] = heap_keys[(slot - 1) / 2];
            slot = (slot - 1) / 2;
          end
          heap_keys[slot] = ka;
          heap_len++;
        end
      end
      KIND_ROOT: r.answer = (heap_pos(ka) == 1);
      KIND_PARENT: begin
        pa = heap_pos(ka);
        pb = heap_pos(kb);
        r.answer = (pa != 0 && pb != 0 && pa == pb / 2);
      end
      KIND_CHILD: begin
        pa = heap_pos(ka);
        pb = heap_pos(kb);
        r.answer = (pa != 0 && pb != 0 && pa / 2 == pb);
      end
      KIND_SIBLING: begin
        pa = heap_pos(ka);
        pb = heap_pos(kb);
        lo = (pa < pb) ? pa : pb;
        hi = (pa < pb) ? pb : pa;
        r.answer = (lo != 0 && hi % 2 == 1 && lo + 1 == hi);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Keys: a narrow band for duplicates, the extremes, and the full range
  function automatic logic signed [15:0] rand_key();
    int pick;
    pick = $urandom_range(99);
    if (pick < 25) return 16'($urandom_range(16)) - 16'd8;
    if (pick < 35) begin
      case ($urandom_range(3))
        0: return 16'h8000;
        1: return 16'h7FFF;
        2: return 16'hFFFF;
        default: return 16'h0000;
      endcase
    end
    return 16'($urandom);
  endfunction

  // Send one item, with an occasional gap before it; predict once accepted
  task automatic send_item(logic [2:0] kind, logic signed [15:0] ka, logic signed [15:0] kb);
    if (!no_gaps && $urandom_range(99) < GAP_PCT) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tuser  <= kind;
    s_tdata  <= {kb, ka};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    due_results.push_back(heap_apply(kind, ka, kb));
  endtask

  // Sender stops and waits for every owed result
  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // Mostly queries on keys that stand in the relation asked, some near misses
  task automatic random_query(output logic [2:0] kind, output logic signed [15:0] ka,
                              output logic signed [15:0] kb);
    int s, c;
    ka = rand_key();
    kb = rand_key();
    case ($urandom_range(3))
      0: kind = KIND_ROOT;
      1: kind = KIND_PARENT;
      2: kind = KIND_CHILD;
      default: kind = KIND_SIBLING;
    endcase
    if (heap_len > 1 && $urandom_range(99) < 80) begin
      c = $urandom_range(1, heap_len - 1);
      case (kind)
        KIND_ROOT: ka = heap_keys[($urandom_range(99) < 60) ? 0 : c];
        KIND_PARENT, KIND_CHILD: begin
          s = (c - 1) / 2;
          if ($urandom_range(3) == 0) s = $urandom_range(heap_len - 1);
          if (kind == KIND_PARENT) begin
            ka = heap_keys[s];
            kb = heap_keys[c];
          end else begin
            ka = heap_keys[c];
            kb = heap_keys[s];
          end
        end
        default: begin
          // odd slot pairs with the next one
          s = (c % 2 == 1) ? c + 1 : c - 1;
          if (s >= heap_len) s = c - 1;
          ka = heap_keys[c];
          kb = heap_keys[s];
        end
      endcase
    end
  endtask

  // Fresh heap: empty queries, extremes, duplicates, each relation, unused kinds
  task automatic test_directed();
    send_item(KIND_ROOT, 16'sd0, 16'sd0);
    send_item(KIND_PARENT, 16'sd0, 16'sd0);
    send_item(KIND_INSERT, 16'sh7FFF, -16'sd1);
    send_item(KIND_INSERT, 16'sh8000, 16'sh7FFF);
    send_item(KIND_INSERT, 16'sd0, 16'sd0);
    send_item(KIND_INSERT, 16'sd100, 16'sh5555);
    send_item(KIND_INSERT, -16'sd1, 16'shAAAA);
    send_item(KIND_INSERT, 16'sd5, 16'sd0);
    send_item(KIND_INSERT, 16'sd5, 16'sd0);
    send_item(KIND_ROOT, 16'sh8000, 16'sh7FFF);
    send_item(KIND_ROOT, 16'sh7FFF, 16'sh8000);
    send_item(KIND_PARENT, heap_keys[0], heap_keys[1]);
    send_item(KIND_PARENT, heap_keys[1], heap_keys[0]);
    send_item(KIND_CHILD, heap_keys[1], heap_keys[0]);
    send_item(KIND_CHILD, heap_keys[3], heap_keys[1]);
    send_item(KIND_SIBLING, heap_keys[1], heap_keys[2]);
    send_item(KIND_SIBLING, heap_keys[2], heap_keys[1]);
    send_item(KIND_SIBLING, heap_keys[2], heap_keys[3]);
    send_item(KIND_SIBLING, 16'sd5, 16'sd5);
    send_item(KIND_PARENT, heap_keys[2], 16'sd5);
    send_item(KIND_ROOT, 16'sd1234, 16'sd0);
    send_item(KIND_PARENT, 16'sd1234, heap_keys[1]);
    send_item(3'd5, 16'sh7FFF, 16'sh8000);
    send_item(3'd6, 16'sh8000, 16'sh7FFF);
    send_item(3'd7, -16'sd1, -16'sd1);
  endtask

  // Random mix with a stretch without gaps and one drain pause
  task automatic test_random();
    logic [2:0]         kind;
    logic signed [15:0] ka, kb;
    int                 roll;
    for (int n = 0; n < 560; n++) begin
      no_gaps = (n >= 200 && n < 280);
      if (n == 320) wait_results_drained();
      roll = $urandom_range(99);
      if (roll < 45) begin
        send_item(KIND_INSERT, rand_key(), rand_key());
      end else if (roll < 95) begin
        random_query(kind, ka, kb);
        send_item(kind, ka, kb);
      end else begin
        send_item(3'($urandom_range(5, 7)), rand_key(), rand_key());
      end
    end
    no_gaps = 1'b0;
  endtask

  // Receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    wait_results_drained();
    hold_pending = 1'b1;
    for (int n = 0; n < 12; n++) begin
      if (n % 4 == 3) send_item(KIND_ROOT, heap_keys[0], rand_key());
      else send_item(KIND_INSERT, rand_key(), rand_key());
    end
  endtask

  // Fill to capacity, then refused inserts and queries over the whole heap
  task automatic test_full_heap();
    int last;
    while (heap_len < HEAP_DEPTH) send_item(KIND_INSERT, rand_key(), rand_key());
    send_item(KIND_INSERT, 16'sh8000, 16'sd0);
    send_item(KIND_INSERT, 16'sh7FFF, 16'sd0);
    send_item(KIND_INSERT, 16'sd0, 16'sd0);
    last = HEAP_DEPTH - 1;
    send_item(KIND_ROOT, heap_keys[0], 16'sd0);
    send_item(KIND_PARENT, heap_keys[(last - 1) / 2], heap_keys[last]);
    send_item(KIND_CHILD, heap_keys[last], heap_keys[(last - 1) / 2]);
    send_item(KIND_SIBLING, heap_keys[last - 1], heap_keys[last]);
    send_item(KIND_SIBLING, heap_keys[last - 2], heap_keys[last - 1]);
    send_item(KIND_ROOT, heap_keys[last], 16'sd0);
    send_item(KIND_INSERT, -16'sd1, 16'sd0);
  endtask

  // Result receiver: random stalls, or a long hold when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        m_tready <= no_gaps || ($urandom_range(99) >= GAP_PCT);
      end
    end
  end

  // Compare each accepted result with the oldest owed one
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (due_results.size() == 0) begin
        $error("unexpected result item: answer %0b, status %0b", m_tdata[0], m_tdata[1]);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (m_tdata[0] !== want.answer) begin
          $error("answer: expected %0b, got %0b", want.answer, m_tdata[0]);
          errors++;
        end
        if (m_tdata[1] !== want.status) begin
          $error("status: expected %0b, got %0b", want.status, m_tdata[1]);
          errors++;
        end
        if (m_tdata[7:2] !== 6'd0) begin
          $error("pad: expected %0h, got %0h", 6'd0, m_tdata[7:2]);
          errors++;
        end
      end
    end
  end

  // Run limit
  initial begin
    #60_000_000;
    $display("min_heap_insert_relation_query_tb NOT OK");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    wait_results_drained();
    test_random();
    test_backpressure();
    test_full_heap();
    wait_results_drained();
    repeat (HEAP_DEPTH + 16) @(posedge clk);
    if (errors == 0 && due_results.size() == 0)
      $display("min_heap_insert_relation_query_tb OK");
    else
      $display("min_heap_insert_relation_query_tb NOT OK");
    $finish;
  end

endmodule
